// File: rtl/spuv_pkg.sv
// ----------------------------------------------------------------------------
// spuv_pkg
// Shared types and constants for the spherical UV mapping pipeline.
// ----------------------------------------------------------------------------
package spuv_pkg;

   // Input coordinate width, signed Q2.13
   localparam int COORD_W = 16;
   // Output coordinate width, unsigned Q1.15
   localparam int TEX_W = 16;

   // Datapath width: inputs scaled to 2^39, passes grow by about 4.7x
   localparam int DATA_W = 45;
   // Binary angle, units of 2^-32 turn, with headroom past +/- half turn
   localparam int ANGLE_W = 34;

   // Longest supported arctangent table
   localparam int MAX_STEPS = 24;

   // CORDIC gain in Q20
   localparam int GAIN_Q20 = 1726753;

   // Half turn in binary angle units
   localparam logic signed [ANGLE_W-1:0] HALF_TURN = 34'sd2147483648;

   // atan(2^-i) in 2^-32 turn, rounded to nearest
   localparam logic signed [ANGLE_W-1:0] ATAN_BAM [MAX_STEPS] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81
   };

   // Vertex position
   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
   } spuv_req_type;

   // Texture coordinates
   typedef struct packed {
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
      logic             zero_length;
   } spuv_rsp_type;

endpackage

// File: rtl/spuv_cordic.sv
// ----------------------------------------------------------------------------
// spuv_cordic
// Pipelined CORDIC vectoring pass: returns atan2(y, x) as a binary angle and
// the radius times the CORDIC gain. One register stage for the quadrant fold,
// then one per iteration. A sideband word travels along with each item.
// ----------------------------------------------------------------------------
module spuv_cordic #(
   parameter int STEPS  = 16,
   parameter int SIDE_W = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic signed [spuv_pkg::DATA_W-1:0]  in_x,
   input  logic signed [spuv_pkg::DATA_W-1:0]  in_y,
   input  logic [SIDE_W-1:0]                   in_side,
   output logic                                out_valid,
   output logic signed [spuv_pkg::ANGLE_W-1:0] out_angle,
   output logic signed [spuv_pkg::DATA_W-1:0]  out_radius,
   output logic [SIDE_W-1:0]                   out_side
);

   localparam int DW = spuv_pkg::DATA_W;
   localparam int AW = spuv_pkg::ANGLE_W;

   // Stage registers: index 0 is after the fold, index STEPS is the result
   logic                 valid_ff [STEPS+1];
   logic                 zero_ff  [STEPS+1];
   logic signed [DW-1:0] x_ff     [STEPS+1];
   logic signed [DW-1:0] y_ff     [STEPS+1];
   logic signed [AW-1:0] acc_ff   [STEPS+1];
   logic [SIDE_W-1:0]    side_ff  [STEPS+1];

   logic                 zero_in;
   logic signed [DW-1:0] fold_x_in;
   logic signed [DW-1:0] fold_y_in;
   logic signed [AW-1:0] fold_acc_in;

   // Quadrant fold: for x < 0 negate the vector and start at +/- half turn
   always_comb begin
      zero_in = (in_x == '0) && (in_y == '0);
      if (in_x[DW-1]) begin
         fold_x_in   = -in_x;
         fold_y_in   = -in_y;
         fold_acc_in = in_y[DW-1] ? -spuv_pkg::HALF_TURN : spuv_pkg::HALF_TURN;
      end else begin
         fold_x_in   = in_x;
         fold_y_in   = in_y;
         fold_acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff[0] <= zero_in;
         x_ff[0]    <= fold_x_in;
         y_ff[0]    <= fold_y_in;
         acc_ff[0]  <= fold_acc_in;
         side_ff[0] <= in_side;
      end
   end

   // One micro-rotation per stage; shifts floor toward minus infinity
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic signed [DW-1:0] x_in;
      logic signed [DW-1:0] y_in;
      logic signed [AW-1:0] acc_in;

      assign dx     = y_ff[i] >>> i;
      assign dy     = x_ff[i] >>> i;
      assign x_in   = y_ff[i][DW-1] ? (x_ff[i] - dx) : (x_ff[i] + dx);
      assign y_in   = y_ff[i][DW-1] ? (y_ff[i] + dy) : (y_ff[i] - dy);
      assign acc_in = y_ff[i][DW-1] ? (acc_ff[i] - spuv_pkg::ATAN_BAM[i])
                                    : (acc_ff[i] + spuv_pkg::ATAN_BAM[i]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            zero_ff[i+1] <= zero_ff[i];
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            acc_ff[i+1]  <= acc_in;
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // A zero vector has angle zero; its radius stays zero through the steps
   assign out_valid  = valid_ff[STEPS];
   assign out_angle  = zero_ff[STEPS] ? '0 : acc_ff[STEPS];
   assign out_radius = x_ff[STEPS];
   assign out_side   = side_ff[STEPS];

endmodule

// File: rtl/spherical_uv_mapping_unit.sv
// Pipeline: a registered input stage, two chained CORDIC vectoring passes and a
// registered output stage; each pass has one fold stage plus one register stage per
// iteration. Throughput: one vertex per cycle while rsp is not held.
// A held rsp stalls the whole pipeline at once, and req_stall follows it.
// Synchronous reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
// spherical_uv_mapping_unit
// Maps a vertex position to spherical texture coordinates (u, v) using two
// CORDIC passes: theta = atan2(y, x), then phi = atan2(|xy| * gain, z * gain).
// ----------------------------------------------------------------------------
module spherical_uv_mapping_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spuv_pkg::spuv_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spuv_pkg::spuv_rsp_type rsp_data
);

   localparam int STEPS = (CORDIC_STEPS > spuv_pkg::MAX_STEPS) ? spuv_pkg::MAX_STEPS
                                                               : CORDIC_STEPS;
   localparam int DW       = spuv_pkg::DATA_W;
   localparam int AW       = spuv_pkg::ANGLE_W;
   localparam int CW       = spuv_pkg::COORD_W;
   localparam int TW       = spuv_pkg::TEX_W;
   // Inputs are scaled so that full scale sits at 2^39
   localparam int XY_SHIFT = 40 - CW;
   // z * gain / 2^20 at the same scale; exact left shift while CW <= 20
   localparam int ZK_SHIFT = 20 - CW;
   localparam int PROD_W   = CW + 22;
   localparam logic signed [PROD_W-1:0] GAIN_S = PROD_W'(spuv_pkg::GAIN_Q20);
   localparam int SIDE_A_W = DW + 1;
   localparam int SIDE_B_W = AW + 1;
   // u path: 2^31 - theta, clamped to [0, 2^32]
   localparam int W_W      = AW + 2;
   localparam logic signed [W_W-1:0] U_BASE = W_W'(spuv_pkg::HALF_TURN);
   localparam logic signed [W_W-1:0] U_MAX  = U_BASE <<< 1;
   localparam logic [TW-1:0]         V_BASE = TW'(16384);

   // Whole pipeline advances unless the output register is held
   logic adv;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ------------------------------------------------------------------
   // Input stage: scale x and y, multiply z by the CORDIC gain
   // ------------------------------------------------------------------
   logic                     in_valid_ff;
   logic                     all_zero_ff;
   logic signed [DW-1:0]     x_ff;
   logic signed [DW-1:0]     y_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic                     all_zero_in;
   logic signed [DW-1:0]     x_in;
   logic signed [DW-1:0]     y_in;
   logic signed [PROD_W-1:0] prod_in;

   assign all_zero_in = (req_data.pos_x == '0) && (req_data.pos_y == '0) &&
                        (req_data.pos_z == '0);
   assign x_in        = DW'(req_data.pos_x) <<< XY_SHIFT;
   assign y_in        = DW'(req_data.pos_y) <<< XY_SHIFT;
   assign prod_in     = PROD_W'(req_data.pos_z) * GAIN_S;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         all_zero_ff <= all_zero_in;
         x_ff        <= x_in;
         y_ff        <= y_in;
         prod_ff     <= prod_in;
      end
   end

   logic signed [DW-1:0] zk;
   assign zk = DW'(prod_ff) <<< ZK_SHIFT;

   // ------------------------------------------------------------------
   // Pass A: theta = atan2(y, x), radius of the xy projection
   // ------------------------------------------------------------------
   logic                 a_valid;
   logic signed [AW-1:0] a_theta;
   logic signed [DW-1:0] a_radius;
   logic [SIDE_A_W-1:0]  a_side;

   spuv_cordic #(
      .STEPS  (STEPS),
      .SIDE_W (SIDE_A_W)
   ) u_pass_a (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (in_valid_ff),
      .in_x       (x_ff),
      .in_y       (y_ff),
      .in_side    ({all_zero_ff, zk}),
      .out_valid  (a_valid),
      .out_angle  (a_theta),
      .out_radius (a_radius),
      .out_side   (a_side)
   );

   // ------------------------------------------------------------------
   // Pass B: phi = atan2(radius, z * gain)
   // ------------------------------------------------------------------
   logic                 b_valid;
   logic signed [AW-1:0] b_phi;
   logic signed [DW-1:0] b_radius;
   logic [SIDE_B_W-1:0]  b_side;
   logic signed [AW-1:0] b_theta;
   logic                 b_zero;

   spuv_cordic #(
      .STEPS  (STEPS),
      .SIDE_W (SIDE_B_W)
   ) u_pass_b (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (a_valid),
      .in_x       (a_side[DW-1:0]),
      .in_y       (a_radius),
      .in_side    ({a_side[DW], a_theta}),
      .out_valid  (b_valid),
      .out_angle  (b_phi),
      .out_radius (b_radius),
      .out_side   (b_side)
   );

   assign b_theta = b_side[AW-1:0];
   assign b_zero  = b_side[AW];

   // ------------------------------------------------------------------
   // Output stage: clamp, round and offset into Q1.15
   // ------------------------------------------------------------------
   logic signed [W_W-1:0]  w_raw;
   logic [AW-2:0]          w_clamp;
   logic [AW-1:0]          u_sum;
   logic [AW-3:0]          p_clamp;
   logic [AW-2:0]          v_sum;
   spuv_pkg::spuv_rsp_type rsp_in;

   always_comb begin
      w_raw = U_BASE - W_W'(b_theta);
      if (w_raw[W_W-1]) begin
         w_clamp = '0;
      end else if (w_raw > U_MAX) begin
         w_clamp = U_MAX[AW-2:0];
      end else begin
         w_clamp = w_raw[AW-2:0];
      end
      u_sum = AW'(w_clamp) + AW'(65536);

      if (b_phi[AW-1]) begin
         p_clamp = '0;
      end else if (b_phi > spuv_pkg::HALF_TURN) begin
         p_clamp = spuv_pkg::HALF_TURN[AW-3:0];
      end else begin
         p_clamp = b_phi[AW-3:0];
      end
      v_sum = (AW-1)'(p_clamp) + (AW-1)'(32768);

      if (b_zero) begin
         rsp_in.tex_u       = '0;
         rsp_in.tex_v       = '0;
         rsp_in.zero_length = 1'b1;
      end else begin
         rsp_in.tex_u       = TW'(u_sum[AW-1:17]);
         rsp_in.tex_v       = V_BASE + TW'(v_sum[AW-2:16]);
         rsp_in.zero_length = 1'b0;
      end
   end

   logic                   rsp_valid_ff;
   spuv_pkg::spuv_rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/spuv_checker.sv
// ----------------------------------------------------------------------------
// spuv_checker
// Port-level checks on the spherical UV mapping unit, bound to the top level.
// ----------------------------------------------------------------------------
module spuv_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input spuv_pkg::spuv_rsp_type rsp_data
);

   // Reset empties the pipeline, so no result shows right after it
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A held result backs up into the request side
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("req_stall low while rsp is held");

   // Zero-length results carry zero coordinates
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_length) |->
         (rsp_data.tex_u == 16'd0 && rsp_data.tex_v == 16'd0))
      else $error("zero_length with nonzero coordinates");

   // Normal results stay within the clamped ranges
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.zero_length) |->
         (rsp_data.tex_u <= 16'd32768 && rsp_data.tex_v >= 16'd16384 &&
          rsp_data.tex_v <= 16'd49152))
      else $error("texture coordinate out of range");

   // A stalled result holds until its transfer
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled rsp changed");

endmodule

bind spherical_uv_mapping_unit spuv_checker u_spuv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
